/* hdl/bsf_pkg.sv */
// ----------------------------------------------------------------------------
// bsf_pkg
// Shared types, line codes and the byte-wise reflected CRC-32 step for the
// byte-stuffed framer.
// ----------------------------------------------------------------------------
package bsf_pkg;

	localparam int unsigned CFG_IDX_W = 8;
	localparam int unsigned STEP_W    = 3;

	localparam logic [7:0] FLAG_BYTE = 8'h7E;
	localparam logic [7:0] ESC_BYTE  = 8'h7D;
	localparam logic [7:0] ESC_FLAG  = 8'h5E;
	localparam logic [7:0] ESC_ESC   = 8'h5D;
	localparam logic [7:0] SEG_FLAG  = 8'hC0;

	localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;
	localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;

	localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_ID = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MESSAGE_ID = 8'd1;

	localparam logic          ACT_DATA = 1'b0;
	localparam logic          ACT_END  = 1'b1;

	// header walk: flag, message id, sequence, channel id, payload
	localparam logic [STEP_W-1:0] OPEN_LAST_STEP = 3'd4;
	// trailer walk: segment flag, four fcs bytes, flag
	localparam logic [STEP_W-1:0] END_LAST_STEP  = 3'd5;

	typedef enum logic [1:0] {
		KIND_DATA = 2'd0,
		KIND_OPEN = 2'd1,
		KIND_END  = 2'd2
	} kind_t;

	typedef struct packed {
		kind_t      kind;
		logic [7:0] data_byte;
	} item_t;

	function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
		logic [31:0] c;
		c = crc ^ {24'd0, b};
		for (int i = 0; i < 8; i++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

endpackage

/* hdl/bsf_in_if.sv */
// ----------------------------------------------------------------------------
// bsf_in_if
// Input item channel: action and payload byte.
// ----------------------------------------------------------------------------
interface bsf_in_if;
	logic       valid;
	logic       ready;
	logic       action;
	logic [7:0] data_byte;

	modport source (output valid, output action, output data_byte, input ready);
	modport sink   (input valid, input action, input data_byte, output ready);
endinterface

/* hdl/bsf_out_if.sv */
// ----------------------------------------------------------------------------
// bsf_out_if
// Line byte channel: framed, escaped byte with last marker.
// ----------------------------------------------------------------------------
interface bsf_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       last;

	modport source (output valid, output out_byte, output last, input ready);
	modport sink   (input valid, input out_byte, input last, output ready);
endinterface

/* hdl/bsf_cfg_if.sv */
// ----------------------------------------------------------------------------
// bsf_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface bsf_cfg_if;
	logic                           valid;
	logic                           ready;
	logic [bsf_pkg::CFG_IDX_W-1:0] index;
	logic [7:0]                     data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

/* hdl/bsf_front.sv */
// ----------------------------------------------------------------------------
// bsf_front
// Accepts input items and classifies each as payload, frame-opening payload
// or end of frame, tracking whether a frame is open.
// ----------------------------------------------------------------------------
module bsf_front (
	input  logic            clk,
	input  logic            arst_n,
	bsf_in_if.sink          item_ch,
	input  logic            q_full,
	output logic            q_push,
	output bsf_pkg::item_t  q_item
);

	logic in_frame_q;

	assign item_ch.ready = !q_full;
	assign q_push        = item_ch.valid && !q_full;

	always_comb begin
		q_item.data_byte = item_ch.data_byte;
		if (item_ch.action == bsf_pkg::ACT_END) begin
			q_item.kind = bsf_pkg::KIND_END;
		end else if (in_frame_q) begin
			q_item.kind = bsf_pkg::KIND_DATA;
		end else begin
			q_item.kind = bsf_pkg::KIND_OPEN;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q <= 1'b0;
		end else if (q_push) begin
			in_frame_q <= (item_ch.action == bsf_pkg::ACT_DATA);
		end
	end

endmodule

/* hdl/bsf_queue.sv */
// ----------------------------------------------------------------------------
// bsf_queue
// Small FIFO of classified items between front and back.
// ----------------------------------------------------------------------------
module bsf_queue #(
	parameter int unsigned DEPTH = 2
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  bsf_pkg::item_t  push_item,
	output logic            full,
	input  logic            pop,
	output logic            head_valid,
	output bsf_pkg::item_t  head_item
);

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	bsf_pkg::item_t mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full       = (count_q == CNT_W'(DEPTH));
	assign head_valid = (count_q != '0);
	assign head_item  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

/* hdl/bsf_back.sv */
// ----------------------------------------------------------------------------
// bsf_back
// Byte sequencer: walks the header, payload or trailer of the head item,
// folds the CRC, escapes and drives the registered line byte output.
// Holds the configuration registers.
// ----------------------------------------------------------------------------
module bsf_back (
	input  logic            clk,
	input  logic            arst_n,
	bsf_cfg_if.sink         cfg_ch,
	bsf_out_if.source       frame_ch,
	input  logic            head_valid,
	input  bsf_pkg::item_t  head_item,
	output logic            pop
);

	logic [7:0]                   channel_id_q;
	logic [7:0]                   message_id_q;
	logic [7:0]                   seq_q;
	logic [31:0]                  crc_q;
	logic [31:0]                  fcs_q;
	logic [bsf_pkg::STEP_W-1:0]   step_q;
	logic                         esc_q;
	logic [7:0]                   esc_byte_q;
	logic                         out_valid_q;
	logic [7:0]                   out_byte_q;
	logic                         out_last_q;

	logic [7:0]  cur_byte;
	logic        cur_raw;
	logic        cur_final;
	logic        needs_esc;
	logic        fire;
	logic [31:0] crc_next;

	assign cfg_ch.ready      = 1'b1;
	assign frame_ch.valid    = out_valid_q;
	assign frame_ch.out_byte = out_byte_q;
	assign frame_ch.last     = out_last_q;

	always_comb begin
		cur_byte  = head_item.data_byte;
		cur_raw   = 1'b0;
		cur_final = 1'b1;
		unique case (head_item.kind)
			bsf_pkg::KIND_OPEN: begin
				cur_final = (step_q == bsf_pkg::OPEN_LAST_STEP);
				unique case (step_q)
					3'd0: begin
						cur_byte = bsf_pkg::FLAG_BYTE;
						cur_raw  = 1'b1;
					end
					3'd1:    cur_byte = message_id_q;
					3'd2:    cur_byte = seq_q;
					3'd3:    cur_byte = channel_id_q;
					default: cur_byte = head_item.data_byte;
				endcase
			end
			bsf_pkg::KIND_END: begin
				cur_final = (step_q == bsf_pkg::END_LAST_STEP);
				unique case (step_q)
					3'd0:    cur_byte = bsf_pkg::SEG_FLAG;
					3'd1:    cur_byte = fcs_q[7:0];
					3'd2:    cur_byte = fcs_q[15:8];
					3'd3:    cur_byte = fcs_q[23:16];
					3'd4:    cur_byte = fcs_q[31:24];
					default: begin
						cur_byte = bsf_pkg::FLAG_BYTE;
						cur_raw  = 1'b1;
					end
				endcase
			end
			default: begin
				cur_byte  = head_item.data_byte;
				cur_final = 1'b1;
			end
		endcase
	end

	assign needs_esc = !cur_raw &&
		((cur_byte == bsf_pkg::FLAG_BYTE) || (cur_byte == bsf_pkg::ESC_BYTE));
	assign crc_next  = bsf_pkg::crc_byte(crc_q, cur_byte);
	assign fire      = head_valid && (!out_valid_q || frame_ch.ready);
	assign pop       = fire && cur_final && (esc_q || !needs_esc);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			channel_id_q <= '0;
			message_id_q <= '0;
		end else if (cfg_ch.valid) begin
			if (cfg_ch.index == bsf_pkg::REG_CHANNEL_ID) begin
				channel_id_q <= cfg_ch.data;
			end else if (cfg_ch.index == bsf_pkg::REG_MESSAGE_ID) begin
				message_id_q <= cfg_ch.data;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_q       <= '0;
			crc_q       <= bsf_pkg::CRC_INIT;
			fcs_q       <= '0;
			step_q      <= '0;
			esc_q       <= 1'b0;
			esc_byte_q  <= '0;
			out_valid_q <= 1'b0;
			out_byte_q  <= '0;
			out_last_q  <= 1'b0;
		end else if (fire) begin
			out_valid_q <= 1'b1;
			if (esc_q) begin
				out_byte_q <= esc_byte_q;
				out_last_q <= cur_final;
				esc_q      <= 1'b0;
				step_q     <= cur_final ? '0 : step_q + 1'b1;
			end else begin
				out_byte_q <= needs_esc ? bsf_pkg::ESC_BYTE : cur_byte;
				if (!cur_raw) begin
					crc_q <= crc_next;
				end
				if (head_item.kind == bsf_pkg::KIND_OPEN && step_q == 3'd0) begin
					crc_q <= bsf_pkg::CRC_INIT;
				end
				if (head_item.kind == bsf_pkg::KIND_OPEN && step_q == 3'd2) begin
					seq_q <= seq_q + 1'b1;
				end
				if (head_item.kind == bsf_pkg::KIND_END && step_q == 3'd0) begin
					fcs_q <= ~crc_next;
				end
				if (needs_esc) begin
					esc_q      <= 1'b1;
					esc_byte_q <= (cur_byte == bsf_pkg::FLAG_BYTE) ?
						bsf_pkg::ESC_FLAG : bsf_pkg::ESC_ESC;
					out_last_q <= 1'b0;
				end else begin
					out_last_q <= cur_final;
					step_q     <= cur_final ? '0 : step_q + 1'b1;
				end
			end
		end else if (frame_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

endmodule

/* hdl/byte_stuffed_framer_crc32_core.sv */
// ----------------------------------------------------------------------------
// byte_stuffed_framer_crc32_core
// Byte-stuffed framer with reflected CRC-32: classifying front, item queue,
// byte sequencer back end.
//
//   channel   dir   payload               handshake
//   item_ch   in    action, data_byte     valid/ready
//   frame_ch  out   out_byte, last        valid/ready
//   cfg_ch    in    index, data           valid/ready (always ready)
//
// The back end sends one line byte per cycle while frame_ch is ready; a
// payload item gives 1 or 2 line bytes, a frame-opening item 5 to 9, an
// end item 6 to 10. An accepted item is written into the queue; its first
// line byte is registered at the output when the item heads the queue.
// The queue decouples the sides; input stalls only when it is full.
// Reset clears state, queue and output; the CRC presets to all ones.
// ----------------------------------------------------------------------------
module byte_stuffed_framer_crc32_core #(
	parameter int unsigned QUEUE_DEPTH = 2
) (
	input  logic      clk,
	input  logic      arst_n,
	bsf_in_if.sink    item_ch,
	bsf_out_if.source frame_ch,
	bsf_cfg_if.sink   cfg_ch
);

	logic           q_push;
	logic           q_full;
	logic           q_pop;
	logic           head_valid;
	bsf_pkg::item_t push_item;
	bsf_pkg::item_t head_item;

	bsf_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.item_ch (item_ch),
		.q_full  (q_full),
		.q_push  (q_push),
		.q_item  (push_item)
	);

	bsf_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_item  (push_item),
		.full       (q_full),
		.pop        (q_pop),
		.head_valid (head_valid),
		.head_item  (head_item)
	);

	bsf_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_ch     (cfg_ch),
		.frame_ch   (frame_ch),
		.head_valid (head_valid),
		.head_item  (head_item),
		.pop        (q_pop)
	);

endmodule

/* bench/byte_stuffed_framer_crc32_core_test.sv */
// ----------------------------------------------------------------------------
// byte_stuffed_framer_crc32_core_test
// Self-checking bench for the byte-stuffed CRC-32 framer. A driver feeds
// action/byte items from a pending queue, and a monitor takes line bytes.
// Both sides insert random idle cycles. Every accepted item is run through
// a local framer model, and each line byte is checked against the oldest
// prediction. Header registers change between phases while the block is idle.
// One phase holds the line side off long enough to back up the input.
// ----------------------------------------------------------------------------
module byte_stuffed_framer_crc32_core_test;
	import bsf_pkg::*;

	localparam int STALL_LIMIT     = 2000;
	localparam int HOLD_OFF_CYCLES = 150;
	localparam int PHASE_ITEMS     = 36;
	localparam int RANDOM_PHASES   = 5;
	localparam int PRESSURE_PHASE  = 3;

	typedef enum int {
		IDLE_NONE,
		IDLE_FULL,
		IDLE_SPARSE
	} idle_mode_t;

	typedef struct {
		logic       action;
		logic [7:0] data;
		int         gap;
	} frame_item_t;

	typedef struct {
		logic [7:0] out_byte;
		logic       last;
	} line_byte_t;

	logic clk = 1'b0;
	logic arst_n;

	bsf_in_if  item_ch ();
	bsf_out_if frame_ch ();
	bsf_cfg_if cfg_ch ();

	byte_stuffed_framer_crc32_core DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.item_ch  (item_ch),
		.frame_ch (frame_ch),
		.cfg_ch   (cfg_ch)
	);

	always #4 clk = ~clk;

	frame_item_t items_to_send[$];
	line_byte_t  line_bytes_due[$];
	line_byte_t  item_bytes[$];

	logic [7:0]  hdr_channel;
	logic [7:0]  hdr_message;
	logic        frame_open;
	logic [7:0]  frame_seq;
	logic [31:0] frame_crc;

	int         errors = 0;
	int         idle_cycles = 0;
	idle_mode_t rx_mode = IDLE_FULL;
	int         rx_wait = 0;
	int         hold_left = 0;
	int         hold_off_req = 0;
	int         hold_off_seen = 0;

	function automatic logic [31:0] fcs_fold(input logic [31:0] crc, input logic [7:0] b);
		logic [31:0] c;
		logic        fb;
		c = crc;
		for (int i = 0; i < 8; i++) begin
			fb = c[0] ^ b[i];
			c = c >> 1;
			if (fb)
				c = c ^ CRC_POLY;
		end
		return c;
	endfunction

	function automatic int draw_gap(input idle_mode_t mode);
		case (mode)
			IDLE_NONE: begin
				return 0;
			end
			IDLE_SPARSE: begin
				return ($urandom_range(0, 3) == 0) ? $urandom_range(1, 12) : 0;
			end
			default: begin
				return $urandom_range(0, 12);
			end
		endcase
	endfunction

	task automatic add_raw(input logic [7:0] b);
		line_byte_t lb;
		lb.out_byte = b;
		lb.last     = 1'b0;
		item_bytes.push_back(lb);
	endtask

	task automatic add_stuffed(input logic [7:0] b);
		frame_crc = fcs_fold(frame_crc, b);
		if (b == FLAG_BYTE) begin
			add_raw(ESC_BYTE);
			add_raw(ESC_FLAG);
		end else if (b == ESC_BYTE) begin
			add_raw(ESC_BYTE);
			add_raw(ESC_ESC);
		end else begin
			add_raw(b);
		end
	endtask

	task automatic predict_line_bytes(input logic action, input logic [7:0] data);
		logic [31:0] fcs;
		line_byte_t  lb;
		item_bytes.delete();
		if (action == ACT_DATA) begin
			if (!frame_open) begin
				frame_crc = CRC_INIT;
				add_raw(FLAG_BYTE);
				add_stuffed(hdr_message);
				add_stuffed(frame_seq);
				frame_seq = frame_seq + 8'd1;
				add_stuffed(hdr_channel);
				frame_open = 1'b1;
			end
			add_stuffed(data);
		end else begin
			add_stuffed(SEG_FLAG);
			fcs = ~frame_crc;
			add_stuffed(fcs[7:0]);
			add_stuffed(fcs[15:8]);
			add_stuffed(fcs[23:16]);
			add_stuffed(fcs[31:24]);
			add_raw(FLAG_BYTE);
			frame_open = 1'b0;
		end
		for (int i = 0; i < item_bytes.size(); i++) begin
			lb      = item_bytes[i];
			lb.last = (i == item_bytes.size() - 1);
			line_bytes_due.push_back(lb);
		end
	endtask

	task automatic check_line_byte(input logic [7:0] got_byte, input logic got_last);
		line_byte_t want;
		if (line_bytes_due.size() == 0) begin
			$display("%0t: unexpected line byte %02h last %0b", $time, got_byte, got_last);
			errors++;
		end else begin
			want = line_bytes_due.pop_front();
			if (got_byte !== want.out_byte) begin
				$display("%0t: out_byte expected %02h got %02h", $time, want.out_byte, got_byte);
				errors++;
			end
			if (got_last !== want.last) begin
				$display("%0t: last expected %0b got %0b", $time, want.last, got_last);
				errors++;
			end
		end
	endtask

	// driver: one item held on the channel until taken
	always @(posedge clk) begin
		frame_item_t nxt;
		if (!arst_n) begin
			item_ch.valid <= 1'b0;
		end else begin
			if (item_ch.valid && item_ch.ready)
				predict_line_bytes(item_ch.action, item_ch.data_byte);
			if (!item_ch.valid || item_ch.ready) begin
				if (items_to_send.size() == 0) begin
					item_ch.valid <= 1'b0;
				end else if (items_to_send[0].gap > 0) begin
					items_to_send[0].gap = items_to_send[0].gap - 1;
					item_ch.valid <= 1'b0;
				end else begin
					nxt = items_to_send.pop_front();
					item_ch.valid     <= 1'b1;
					item_ch.action    <= nxt.action;
					item_ch.data_byte <= nxt.data;
				end
			end
		end
	end

	// monitor: random wait before each line byte, long hold-off on request
	always @(posedge clk) begin
		if (!arst_n) begin
			frame_ch.ready <= 1'b0;
		end else begin
			if (frame_ch.valid && frame_ch.ready) begin
				check_line_byte(frame_ch.out_byte, frame_ch.last);
				rx_wait = draw_gap(rx_mode);
			end
			if (hold_off_req != hold_off_seen) begin
				hold_off_seen = hold_off_req;
				hold_left     = HOLD_OFF_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				frame_ch.ready <= 1'b0;
			end else if (rx_wait > 0) begin
				rx_wait--;
				frame_ch.ready <= 1'b0;
			end else begin
				frame_ch.ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (item_ch.valid && item_ch.ready) || (frame_ch.valid && frame_ch.ready)
				|| (cfg_ch.valid && cfg_ch.ready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("%0t: no progress for %0d cycles", $time, idle_cycles);
				$display("status: fail");
				$finish;
			end
		end
	end

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
		@(posedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= val;
		do
			@(posedge clk);
		while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
		if (idx == REG_CHANNEL_ID)
			hdr_channel = val;
		else if (idx == REG_MESSAGE_ID)
			hdr_message = val;
	endtask

	// sampled away from the rising edge so the driver's updates have landed
	task automatic settle();
		while (items_to_send.size() != 0 || item_ch.valid || line_bytes_due.size() != 0)
			@(negedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic queue_item(input logic action, input logic [7:0] data, input idle_mode_t mode);
		frame_item_t it;
		it.action = action;
		it.data   = data;
		it.gap    = draw_gap(mode);
		items_to_send.push_back(it);
	endtask

	function automatic logic [7:0] pick_payload();
		case ($urandom_range(0, 7))
			0: return FLAG_BYTE;
			1: return ESC_BYTE;
			2: begin
				case ($urandom_range(0, 4))
					0: return 8'h00;
					1: return 8'hFF;
					2: return SEG_FLAG;
					3: return ESC_FLAG;
					default: return ESC_ESC;
				endcase
			end
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	initial begin
		idle_mode_t tx_mode;
		int         n;
		int         len;
		arst_n            = 1'b0;
		item_ch.valid     = 1'b0;
		item_ch.action    = ACT_DATA;
		item_ch.data_byte = 8'h00;
		frame_ch.ready    = 1'b0;
		cfg_ch.valid      = 1'b0;
		cfg_ch.index      = REG_CHANNEL_ID;
		cfg_ch.data       = 8'h00;
		hdr_channel       = 8'h00;
		hdr_message       = 8'h00;
		frame_open        = 1'b0;
		frame_seq         = 8'h00;
		frame_crc         = CRC_INIT;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		write_reg(REG_CHANNEL_ID, 8'hFF);
		write_reg(REG_MESSAGE_ID, 8'h00);
		// trailer with no frame open, then again on the residue
		queue_item(ACT_END, 8'hA5, IDLE_FULL);
		queue_item(ACT_END, 8'h00, IDLE_FULL);
		queue_item(ACT_DATA, 8'h00, IDLE_FULL);
		queue_item(ACT_DATA, 8'hFF, IDLE_FULL);
		queue_item(ACT_DATA, FLAG_BYTE, IDLE_FULL);
		queue_item(ACT_DATA, ESC_BYTE, IDLE_FULL);
		queue_item(ACT_DATA, SEG_FLAG, IDLE_FULL);
		queue_item(ACT_DATA, ESC_FLAG, IDLE_FULL);
		queue_item(ACT_DATA, ESC_ESC, IDLE_FULL);
		queue_item(ACT_END, 8'hFF, IDLE_FULL);
		queue_item(ACT_DATA, 8'h01, IDLE_NONE);
		queue_item(ACT_END, 8'h7E, IDLE_NONE);
		settle();

		// header bytes that need escaping
		write_reg(REG_CHANNEL_ID, FLAG_BYTE);
		write_reg(REG_MESSAGE_ID, ESC_BYTE);
		queue_item(ACT_DATA, FLAG_BYTE, IDLE_SPARSE);
		queue_item(ACT_DATA, 8'h80, IDLE_SPARSE);
		queue_item(ACT_END, 8'h55, IDLE_SPARSE);
		queue_item(ACT_END, 8'hAA, IDLE_SPARSE);
		queue_item(ACT_DATA, ESC_BYTE, IDLE_SPARSE);
		queue_item(ACT_END, 8'h00, IDLE_SPARSE);
		settle();

		for (int p = 0; p < RANDOM_PHASES; p++) begin
			if (p == 0) begin
				write_reg(REG_CHANNEL_ID, 8'h00);
				write_reg(REG_MESSAGE_ID, 8'hFF);
			end else begin
				write_reg(REG_CHANNEL_ID, 8'($urandom_range(0, 255)));
				write_reg(REG_MESSAGE_ID, 8'($urandom_range(0, 255)));
			end
			tx_mode = idle_mode_t'(p % 3);
			rx_mode <= idle_mode_t'((p + 1) % 3);
			if (p == PRESSURE_PHASE) begin
				tx_mode = IDLE_NONE;
				hold_off_req <= hold_off_req + 1;
			end
			n = 0;
			while (n < PHASE_ITEMS) begin
				if ($urandom_range(0, 9) == 0) begin
					// stray end request
					queue_item(ACT_END, 8'($urandom_range(0, 255)), tx_mode);
					n++;
				end else begin
					len = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 12) : $urandom_range(1, 5);
					for (int k = 0; k < len; k++)
						queue_item(ACT_DATA, pick_payload(), tx_mode);
					// occasionally leave the frame open across the next one
					if ($urandom_range(0, 7) != 0)
						queue_item(ACT_END, 8'($urandom_range(0, 255)), tx_mode);
					n += len + 1;
				end
			end
			settle();
		end

		repeat (8) @(posedge clk);
		if (errors == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule
